// ===== rtl/core/rds_pkg.sv =====
`default_nettype none

package rds_pkg;

  // fixed widths of the channel fields
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned MEAN_OUT_W  = 48;
  localparam int unsigned VAR_W       = 64;
  localparam int unsigned VALUE_W     = 32;

  // action codes
  localparam logic ACT_CLOSE   = 1'b0;
  localparam logic ACT_PARTIAL = 1'b1;

  typedef struct packed {
    logic             action;
    logic [DUR_W-1:0] duration;
  } sample_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] sample_count;
    logic [MEAN_OUT_W-1:0]  mean_value;
    logic [VAR_W-1:0]       variance_value;
    logic [VALUE_W-1:0]     min_value;
    logic [VALUE_W-1:0]     max_value;
    logic                   pending_flag;
    logic [VALUE_W-1:0]     pending_sum;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_ACC,
    S_VAR_GO,
    S_VAR_WAIT,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/rds_stream_if.sv =====
`default_nettype none

interface rds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rds_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module rds_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [DW-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

`default_nettype wire

// ===== rtl/core/rds_mul.sv =====
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module rds_mul #(
  parameter int unsigned W = 48
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                done_o,
  output logic      [2*W-1:0] product_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]   a_q, a_d;
  logic [2*W-1:0] p_q, p_d;
  logic [W:0]     sum;

  assign sum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      a_d    = a_i;
      p_d    = {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_d   = {sum, p_q[W-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign done_o    = done_q;
  assign product_o = p_q;
endmodule

`default_nettype wire

// ===== rtl/core/running_duration_statistics.sv =====
`default_nettype none

// channel    dir  modport  payload            transfer
// sample_i   in   sink     action, duration   valid && ready
// result_o   out  source   seven stat fields  valid && ready
//
// a partial item goes to S_FINISH, then to the output register; the next item transfers in S_IDLE
// a closing item runs through two passes of the bit-serial divider (mean step, variance)
// and one of the shift-add multiplier; below two samples the variance pass is skipped
// reset clears all statistics at once, no sweep
// a result waits in the output register; a new item is taken meanwhile and its own
// result holds in the last step until the register frees up
module running_duration_statistics #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rds_stream_if.sink   sample_i,
  rds_stream_if.source result_o
);
  import rds_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned MW = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned DW = (MW > VAR_W) ? MW : VAR_W;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned XW = (PW > VAR_W) ? PW : VAR_W;
  localparam int unsigned EW = (SB > DUR_W) ? SB : DUR_W;

  state_e state_q, state_d;

  logic          in_ready;
  logic          div_start;
  logic          div_sel_var;
  logic          mul_start;
  logic          out_load;

  logic [CB-1:0]    count_q;
  logic [MW-1:0]    mean_q;
  logic [VAR_W-1:0] sq_q;
  logic [VAR_W-1:0] var_q;
  logic [SB-1:0]    min_q;
  logic [SB-1:0]    max_q;
  logic [SB-1:0]    partial_q;

  logic [SB-1:0]    x_q;
  logic [MW-1:0]    e1_q;
  logic             up_q;
  logic [VAR_W-1:0] prod_q;

  result_t res_q;
  logic    out_valid_q;

  logic [EW-1:0] dur_ext;
  logic [SB-1:0] d_sat;
  logic [SB:0]   part_sum;
  logic [SB:0]   close_sum;
  logic          accept;
  logic          count_ge2;

  logic [MW-1:0] big;
  logic [MW-1:0] e1;
  logic [MW-1:0] e2;
  logic [MW-1:0] step;
  logic          big_ge;

  logic [DW-1:0]   div_dividend;
  logic [CB-1:0]   div_divisor;
  logic            div_done;
  logic [DW-1:0]   div_quo;
  logic            mul_done;
  logic [PW-1:0]   mul_prod;
  logic [PW-1:0]   prod_sh;
  logic [XW-1:0]   prod_ext;
  logic            prod_ovf;
  logic [VAR_W:0]  sq_sum;

  assign accept = sample_i.valid && in_ready;

  // clamp the duration to the sample range
  assign dur_ext   = EW'(sample_i.payload.duration);
  assign d_sat     = ((dur_ext >> SB) != '0) ? '1 : dur_ext[SB-1:0];
  assign part_sum  = {1'b0, partial_q} + {1'b0, d_sat};
  assign close_sum = {1'b0, d_sat} + {1'b0, partial_q};

  assign big    = MW'(x_q) << FRAC_BITS;
  assign big_ge = big >= mean_q;
  assign e1     = big_ge ? big - mean_q : mean_q - big;
  assign e2     = up_q ? big - mean_q : mean_q - big;
  assign step   = div_quo[MW-1:0];

  assign count_ge2 = (count_q >> 1) != '0;

  assign div_dividend = div_sel_var ? DW'(sq_q) : DW'(e1_q);
  assign div_divisor  = div_sel_var ? count_q - CB'(1) : count_q;

  // product >> FRAC_BITS, saturated to the error-sum width
  assign prod_sh  = mul_prod >> FRAC_BITS;
  assign prod_ext = XW'(prod_sh);
  assign prod_ovf = (prod_ext >> VAR_W) != '0;

  assign sq_sum = {1'b0, sq_q} + {1'b0, prod_q};

  rds_div #(
    .DW (DW),
    .VW (CB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rds_mul #(
    .W (MW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (e1_q),
    .b_i       (e2),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (sample_i.payload.action == ACT_PARTIAL) ? S_FINISH : S_PREP;
        end
      end
      S_PREP:      state_d = S_MEAN_GO;
      S_MEAN_GO:   state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_done) state_d = S_MUL_GO;
      S_MUL_GO:    state_d = S_MUL_WAIT;
      S_MUL_WAIT:  if (mul_done) state_d = S_ACC;
      S_ACC:       state_d = S_VAR_GO;
      S_VAR_GO:    state_d = count_ge2 ? S_VAR_WAIT : S_FINISH;
      S_VAR_WAIT:  if (div_done) state_d = S_FINISH;
      S_FINISH:    if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    div_sel_var = 1'b0;
    mul_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE:    in_ready = 1'b1;
      S_MEAN_GO: div_start = 1'b1;
      S_MUL_GO:  mul_start = 1'b1;
      S_VAR_GO: begin
        div_start   = count_ge2;
        div_sel_var = 1'b1;
      end
      S_VAR_WAIT: div_sel_var = 1'b1;
      S_FINISH:   out_load = !out_valid_q || result_o.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      mean_q      <= '0;
      sq_q        <= '0;
      var_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      partial_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (sample_i.payload.action == ACT_PARTIAL) begin
          partial_q <= part_sum[SB] ? '1 : part_sum[SB-1:0];
        end else begin
          partial_q <= '0;
        end
      end
      if (state_q == S_PREP) begin
        if (count_q != '1) begin
          count_q <= count_q + CB'(1);
        end
        if (x_q < min_q) begin
          min_q <= x_q;
        end
        if (x_q > max_q) begin
          max_q <= x_q;
        end
      end
      if (state_q == S_MEAN_WAIT && div_done) begin
        mean_q <= up_q ? mean_q + step : mean_q - step;
      end
      if (state_q == S_ACC) begin
        sq_q <= sq_sum[VAR_W] ? '1 : sq_sum[VAR_W-1:0];
      end
      if (state_q == S_VAR_GO && !count_ge2) begin
        var_q <= '0;
      end
      if (state_q == S_VAR_WAIT && div_done) begin
        var_q <= div_quo[VAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && sample_i.payload.action == ACT_CLOSE) begin
      x_q <= close_sum[SB] ? '1 : close_sum[SB-1:0];
    end
    if (state_q == S_PREP) begin
      e1_q <= e1;
      up_q <= big_ge;
    end
    if (state_q == S_MUL_WAIT && mul_done) begin
      prod_q <= prod_ovf ? '1 : prod_ext[VAR_W-1:0];
    end
    if (out_load) begin
      res_q.sample_count   <= COUNT_OUT_W'(count_q);
      res_q.mean_value     <= MEAN_OUT_W'(mean_q);
      res_q.variance_value <= var_q;
      res_q.min_value      <= VALUE_W'(min_q);
      res_q.max_value      <= VALUE_W'(max_q);
      res_q.pending_flag   <= partial_q != '0;
      res_q.pending_sum    <= VALUE_W'(partial_q);
    end
  end

  assign sample_i.ready  = in_ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.payload = res_q;
endmodule

`default_nettype wire

// ===== rtl/core/rds_checker.sv =====
`default_nettype none

module rds_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire rds_pkg::result_t result_i
);
  import rds_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] open_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      open_q <= open_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      open_q <= open_q - 2'd1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i))
    else $error("result changed while stalled");

  a_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 2'd2 && !(out_xfer && open_q == 2'd0))
    else $error("result count does not match item count");

  a_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> result_i.pending_flag == (result_i.pending_sum != '0))
    else $error("pending flag disagrees with pending sum");

  a_var_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_i.sample_count == COUNT_OUT_W'(0) ||
                    result_i.sample_count == COUNT_OUT_W'(1))
    |-> result_i.variance_value == '0)
    else $error("variance nonzero below two samples");
endmodule

bind running_duration_statistics rds_checker u_rds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .result_i    (result_o.payload)
);

`default_nettype wire

// ===== verif/tb_running_duration_statistics.sv =====
`timescale 1ns / 100ps

module tb_running_duration_statistics;
  import rds_pkg::*;

  localparam int unsigned SAMPLE_BITS  = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned COUNT_BITS   = 32;
  localparam int          RANDOM_ITEMS = 1430;
  localparam int          HOLD_AFTER   = 200;
  localparam int          HOLD_CYCLES  = 800;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          LIMIT_CYCLES = 5_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni;

  rds_stream_if #(.payload_t(sample_t)) sample_if ();
  rds_stream_if #(.payload_t(result_t)) result_if ();

  running_duration_statistics #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sample_t sample_q[$];
  result_t stats_expected_q[$];

  int   total_items  = 0;
  int   items_taken  = 0;
  int   results_seen = 0;
  int   err_count    = 0;
  int   cycle_count  = 0;
  int   gap_left;
  int   stall_left;
  int   hold_left;
  logic hold_done;
  logic rx_hold;

  assign rx_hold = (hold_left != 0);

  // predictor state
  logic [COUNT_BITS-1:0]  closed_count;
  logic [63:0]            mean_fx;
  logic [63:0]            sq_err_fx;
  logic [SAMPLE_BITS-1:0] min_seen;
  logic [SAMPLE_BITS-1:0] max_seen;
  logic [SAMPLE_BITS-1:0] pending_acc;

  function automatic result_t predict_stats(sample_t s);
    logic [SAMPLE_BITS:0]   sum_w;
    logic [SAMPLE_BITS-1:0] x;
    logic [63:0]            n;
    logic [63:0]            big;
    logic [63:0]            e1;
    logic [63:0]            e2;
    logic [63:0]            step;
    logic [63:0]            inc;
    logic [127:0]           prod;
    logic [64:0]            acc;
    logic                   up;
    result_t                r;
    if (s.action == ACT_PARTIAL) begin
      sum_w       = {1'b0, pending_acc} + s.duration;
      pending_acc = sum_w[SAMPLE_BITS] ? '1 : sum_w[SAMPLE_BITS-1:0];
    end else begin
      sum_w       = {1'b0, s.duration} + pending_acc;
      x           = sum_w[SAMPLE_BITS] ? '1 : sum_w[SAMPLE_BITS-1:0];
      pending_acc = '0;
      if (closed_count != '1) closed_count = closed_count + 1'b1;
      n    = 64'(closed_count);
      big  = 64'(x) << FRAC_BITS;
      up   = big >= mean_fx;
      e1   = up ? big - mean_fx : mean_fx - big;
      step = e1 / n;
      mean_fx = up ? mean_fx + step : mean_fx - step;
      e2   = up ? big - mean_fx : mean_fx - big;
      prod = ({64'b0, e1} * {64'b0, e2}) >> FRAC_BITS;
      inc  = (prod[127:64] != '0) ? '1 : prod[63:0];
      acc  = {1'b0, sq_err_fx} + inc;
      sq_err_fx = acc[64] ? '1 : acc[63:0];
      if (x < min_seen) min_seen = x;
      if (x > max_seen) max_seen = x;
    end
    r.sample_count   = closed_count;
    r.mean_value     = mean_fx[MEAN_OUT_W-1:0];
    r.variance_value = (closed_count >= 2) ? sq_err_fx / (64'(closed_count) - 64'd1) : '0;
    r.min_value      = min_seen;
    r.max_value      = max_seen;
    r.pending_flag   = (pending_acc != '0);
    r.pending_sum    = pending_acc;
    return r;
  endfunction

  function automatic int field_mismatch(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches without any
  function automatic int pick_idle(int progress);
    int r;
    r = $urandom_range(0, 99);
    if ((progress / 150) % 4 == 3) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(40, 250);
  endfunction

  // keeps the squared-error sum clear of saturation during the random part
  function automatic logic [DUR_W-1:0] moderate_duration();
    int w;
    w = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 16) : $urandom_range(17, 18);
    return $urandom & ((32'd1 << w) - 1);
  endfunction

  function automatic logic ACT_LOGIC_RAND();
    return ($urandom_range(0, 1) == 1) ? ACT_PARTIAL : ACT_CLOSE;
  endfunction

  task automatic add_item(logic act, logic [DUR_W-1:0] dur);
    sample_t s;
    s.action   = act;
    s.duration = dur;
    sample_q.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic moved;
    if (!rst_ni) begin
      sample_if.valid   <= 1'b0;
      sample_if.payload <= '0;
      gap_left          <= 0;
    end else begin
      moved = sample_if.valid && sample_if.ready;
      if (moved) begin
        stats_expected_q.push_back(predict_stats(sample_if.payload));
        items_taken <= items_taken + 1;
      end
      if (!sample_if.valid || moved) begin
        if (gap_left > 0 && !rx_hold) begin
          gap_left        <= gap_left - 1;
          sample_if.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_if.valid   <= 1'b1;
          sample_if.payload <= sample_q.pop_front();
          gap_left          <= pick_idle(items_taken);
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    logic    moved;
    int      s;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else begin
      moved = result_if.valid && result_if.ready;
      if (moved) begin
        got = result_if.payload;
        if (stats_expected_q.size() == 0) begin
          $error("result transfer with nothing expected: count 0x%0h", got.sample_count);
          err_count = err_count + 1;
        end else begin
          want = stats_expected_q.pop_front();
          err_count = err_count
            + field_mismatch("sample_count", 64'(want.sample_count), 64'(got.sample_count))
            + field_mismatch("mean_value", 64'(want.mean_value), 64'(got.mean_value))
            + field_mismatch("variance_value", want.variance_value, got.variance_value)
            + field_mismatch("min_value", 64'(want.min_value), 64'(got.min_value))
            + field_mismatch("max_value", 64'(want.max_value), 64'(got.max_value))
            + field_mismatch("pending_flag", 64'(want.pending_flag), 64'(got.pending_flag))
            + field_mismatch("pending_sum", 64'(want.pending_sum), 64'(got.pending_sum));
        end
        results_seen <= results_seen + 1;
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left       <= hold_left - 1;
        result_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left       <= HOLD_CYCLES;
        hold_done       <= 1'b1;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left      <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else if (moved) begin
        s = pick_idle(results_seen);
        if (s > 0) begin
          stall_left      <= s - 1;
          result_if.ready <= 1'b0;
        end else begin
          result_if.ready <= 1'b1;
        end
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int n_random;
    int parts;
    rst_ni            = 1'b0;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    result_if.ready   = 1'b0;
    closed_count      = '0;
    mean_fx           = '0;
    sq_err_fx         = '0;
    min_seen          = '1;
    max_seen          = '0;
    pending_acc       = '0;

    // opening: first sample, empty partial, pending pieces, zero sample
    add_item(ACT_CLOSE,   32'd1000);
    add_item(ACT_PARTIAL, 32'd0);
    add_item(ACT_PARTIAL, 32'd5);
    add_item(ACT_PARTIAL, 32'd7);
    add_item(ACT_CLOSE,   32'd3);
    add_item(ACT_CLOSE,   32'd0);
    add_item(ACT_CLOSE,   32'd20000);

    // random: mostly partial pieces followed by a close, some loose items
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        add_item(ACT_LOGIC_RAND(), moderate_duration());
        n_random++;
      end else begin
        parts = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 3);
        repeat (parts) add_item(ACT_PARTIAL, moderate_duration());
        add_item(ACT_CLOSE, moderate_duration());
        n_random = n_random + parts + 1;
      end
    end

    // extremes last, since they saturate the squared-error sum
    add_item(ACT_PARTIAL, 32'hFFFF_FFFF);
    add_item(ACT_PARTIAL, 32'd1);
    add_item(ACT_PARTIAL, 32'hFFFF_FFFF);
    add_item(ACT_CLOSE,   32'hFFFF_FFFF);
    add_item(ACT_PARTIAL, 32'h8000_0000);
    add_item(ACT_CLOSE,   32'h8000_0000);
    add_item(ACT_CLOSE,   32'hFFFF_FFFF);
    add_item(ACT_CLOSE,   32'd0);
    add_item(ACT_PARTIAL, 32'h5555_5555);
    add_item(ACT_CLOSE,   32'hAAAA_AAAA);
    repeat (8) add_item(ACT_LOGIC_RAND(), $urandom);

    total_items = sample_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_taken != total_items) @(posedge clk_i);
    while (stats_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
